// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the culling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define GCFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define GCFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/gcfc_pkg.sv =====
// Types and constants of the grid cell frustum culling block.
package gcfc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;
    localparam int IDX_W       = 5;   // cell index per axis
    localparam int IDX_CMP_W   = 11;  // holds any grid size up to 1024
    localparam int EDGE_W      = 16;
    localparam int FIELD_W     = 16;  // plane and origin fields
    localparam int SPAN_W      = IDX_W + EDGE_W;   // index * edge
    localparam int COORD_W     = SPAN_W + 2;       // origin + span + edge, signed
    localparam int PROD_W      = FIELD_W + COORD_W;
    localparam int DIST_W      = PROD_W + 2;       // three products and offset
    localparam int Q_FRAC      = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ORIGIN_W    = 3 * FIELD_W;

    // plane word layout
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = 16;
    localparam int NZ_LSB  = 32;
    localparam int OFF_LSB = 48;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PLANE0      = 3'd0;
    localparam cfg_idx_t REG_GRID_ORIGIN = 3'd6;
    localparam cfg_idx_t REG_CELL_EDGE   = 3'd7;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef struct packed {
        logic [IDX_W-1:0] cell_x;
        logic [IDX_W-1:0] cell_y;
        logic [IDX_W-1:0] cell_z;
    } in_item_t;

    typedef struct packed {
        logic visible;
        logic fully_inside;
    } out_item_t;

    // what travels down the chain of plane cells
    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
        logic   culled;   // some plane has all corners outside, or index off grid
        logic   clipped;  // some corner outside some plane
    } tok_t;

endpackage

// ===== hw/rtl/gcfc_box.sv =====
// Front end: cell index to box bounds, grid range check.
module gcfc_box #(
    parameter int CELLS_PER_AXIS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            cfg_wr_en,
    input  gcfc_pkg::cfg_idx_t              cfg_index,
    input  logic [gcfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    input  gcfc_pkg::in_item_t              in_item,
    output logic                            out_valid,
    output gcfc_pkg::tok_t                  out_tok
);

    logic [gcfc_pkg::ORIGIN_W-1:0] origin_reg;
    logic [gcfc_pkg::EDGE_W-1:0]   edge_reg;

    logic                          a_valid_reg;
    logic                          a_oob_reg;
    logic [2:0][gcfc_pkg::SPAN_W-1:0] a_span_reg;

    logic                          b_valid_reg;
    gcfc_pkg::tok_t                b_tok_reg;

    logic [2:0][gcfc_pkg::IDX_W-1:0]  idx;
    logic [2:0][gcfc_pkg::SPAN_W-1:0] span_next;
    logic                          oob_next;
    gcfc_pkg::coord_t              org [3];
    gcfc_pkg::coord_t              lo  [3];
    gcfc_pkg::coord_t              hi  [3];
    gcfc_pkg::coord_t              edge_c;
    gcfc_pkg::tok_t                b_tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            edge_reg   <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == gcfc_pkg::REG_GRID_ORIGIN) begin
                origin_reg <= cfg_wdata[gcfc_pkg::ORIGIN_W-1:0];
            end
            if (cfg_index == gcfc_pkg::REG_CELL_EDGE) begin
                edge_reg <= cfg_wdata[gcfc_pkg::EDGE_W-1:0];
            end
        end
    end

    // stage A: index * edge, range check
    always_comb begin
        idx[0]   = in_item.cell_x;
        idx[1]   = in_item.cell_y;
        idx[2]   = in_item.cell_z;
        oob_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            span_next[a] = gcfc_pkg::SPAN_W'(idx[a]) * gcfc_pkg::SPAN_W'(edge_reg);
            if (gcfc_pkg::IDX_CMP_W'(idx[a]) >= gcfc_pkg::IDX_CMP_W'(CELLS_PER_AXIS)) begin
                oob_next = 1'b1;
            end
        end
    end

    // stage B: origin + span, and the far side
    always_comb begin
        edge_c = gcfc_pkg::coord_t'(edge_reg);
        for (int a = 0; a < 3; a++) begin
            org[a] = gcfc_pkg::coord_t'(signed'(origin_reg[a*gcfc_pkg::FIELD_W +:
                                                          gcfc_pkg::FIELD_W]));
            lo[a]  = org[a] + gcfc_pkg::coord_t'(a_span_reg[a]);
            hi[a]  = org[a] + gcfc_pkg::coord_t'(a_span_reg[a]) + edge_c;
        end
        b_tok_next.lo_x    = lo[0];
        b_tok_next.lo_y    = lo[1];
        b_tok_next.lo_z    = lo[2];
        b_tok_next.hi_x    = hi[0];
        b_tok_next.hi_y    = hi[1];
        b_tok_next.hi_z    = hi[2];
        b_tok_next.culled  = a_oob_reg;
        b_tok_next.clipped = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_span_reg <= span_next;
            a_oob_reg  <= oob_next;
            b_tok_reg  <= b_tok_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_tok   = b_tok_reg;

endmodule

// ===== hw/rtl/gcfc_plane_cell.sv =====
// One plane of the chain: holds the plane, tests eight corners in three stages.
module gcfc_plane_cell #(
    parameter gcfc_pkg::cfg_idx_t REG_SEL = gcfc_pkg::REG_PLANE0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            cfg_wr_en,
    input  gcfc_pkg::cfg_idx_t              cfg_index,
    input  logic [gcfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    input  gcfc_pkg::tok_t                  in_tok,
    output logic                            out_valid,
    output gcfc_pkg::tok_t                  out_tok
);

    logic [gcfc_pkg::CFG_DATA_W-1:0] plane_reg;

    logic             s1_valid_reg;
    gcfc_pkg::tok_t   s1_tok_reg;
    gcfc_pkg::prod_t  s1_px_reg [2];   // [0] lo, [1] hi
    gcfc_pkg::prod_t  s1_py_reg [2];
    gcfc_pkg::prod_t  s1_pz_reg [2];

    logic             s2_valid_reg;
    gcfc_pkg::tok_t   s2_tok_reg;
    gcfc_pkg::dist_t  s2_sxy_reg [4];  // {x side, y side}
    gcfc_pkg::dist_t  s2_sz_reg  [2];  // z term minus scaled offset

    logic             s3_valid_reg;
    gcfc_pkg::tok_t   s3_tok_reg;

    gcfc_pkg::field_t nx, ny, nz, off;
    gcfc_pkg::prod_t  px_next [2];
    gcfc_pkg::prod_t  py_next [2];
    gcfc_pkg::prod_t  pz_next [2];
    gcfc_pkg::dist_t  sxy_next [4];
    gcfc_pkg::dist_t  sz_next  [2];
    gcfc_pkg::dist_t  off_q;
    logic [gcfc_pkg::NUM_CORNERS-1:0] outside;
    gcfc_pkg::tok_t   s3_tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (cfg_wr_en && cfg_index == REG_SEL) begin
            plane_reg <= cfg_wdata;
        end
    end

    assign nx  = signed'(plane_reg[gcfc_pkg::NX_LSB  +: gcfc_pkg::FIELD_W]);
    assign ny  = signed'(plane_reg[gcfc_pkg::NY_LSB  +: gcfc_pkg::FIELD_W]);
    assign nz  = signed'(plane_reg[gcfc_pkg::NZ_LSB  +: gcfc_pkg::FIELD_W]);
    assign off = signed'(plane_reg[gcfc_pkg::OFF_LSB +: gcfc_pkg::FIELD_W]);

    // stage 1: normal component times both box bounds per axis
    always_comb begin
        px_next[0] = gcfc_pkg::prod_t'(nx) * gcfc_pkg::prod_t'(in_tok.lo_x);
        px_next[1] = gcfc_pkg::prod_t'(nx) * gcfc_pkg::prod_t'(in_tok.hi_x);
        py_next[0] = gcfc_pkg::prod_t'(ny) * gcfc_pkg::prod_t'(in_tok.lo_y);
        py_next[1] = gcfc_pkg::prod_t'(ny) * gcfc_pkg::prod_t'(in_tok.hi_y);
        pz_next[0] = gcfc_pkg::prod_t'(nz) * gcfc_pkg::prod_t'(in_tok.lo_z);
        pz_next[1] = gcfc_pkg::prod_t'(nz) * gcfc_pkg::prod_t'(in_tok.hi_z);
    end

    // stage 2: partial sums, offset in Q.14
    always_comb begin
        off_q = gcfc_pkg::dist_t'(off) <<< gcfc_pkg::Q_FRAC;
        for (int j = 0; j < 4; j++) begin
            sxy_next[j] = gcfc_pkg::dist_t'(s1_px_reg[j / 2]) +
                          gcfc_pkg::dist_t'(s1_py_reg[j % 2]);
        end
        for (int k = 0; k < 2; k++) begin
            sz_next[k] = gcfc_pkg::dist_t'(s1_pz_reg[k]) - off_q;
        end
    end

    // stage 3: eight distances, strictly positive is outside
    always_comb begin
        for (int c = 0; c < gcfc_pkg::NUM_CORNERS; c++) begin
            outside[c] = (s2_sxy_reg[c / 2] + s2_sz_reg[c % 2]) > gcfc_pkg::dist_t'(0);
        end
        s3_tok_next         = s2_tok_reg;
        s3_tok_next.culled  = s2_tok_reg.culled  | (&outside);
        s3_tok_next.clipped = s2_tok_reg.clipped | (|outside);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tok_reg <= in_tok;
            s1_px_reg  <= px_next;
            s1_py_reg  <= py_next;
            s1_pz_reg  <= pz_next;
            s2_tok_reg <= s1_tok_reg;
            s2_sxy_reg <= sxy_next;
            s2_sz_reg  <= sz_next;
            s3_tok_reg <= s3_tok_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_tok   = s3_tok_reg;

endmodule

// ===== hw/rtl/grid_cell_frustum_cull.sv =====
// Grid cell frustum culling: index to box, six-plane chain, output with skid.
// Pipeline: 2 box stages, 3 stages in each of the 6 plane cells, and
//   1 output register.
// Throughput: one item per cycle; the pipeline freezes only while the skid
//   register holds an item that the output side has not yet taken.
// Reset: aresetn, synchronous, active low; clears all config registers to 0
//   and empties the pipeline; ready is high the cycle after reset.
`include "assert_macros.svh"

module grid_cell_frustum_cull #(
    parameter int CELLS_PER_AXIS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // config write port
    input  logic                            cfg_wr_en,
    input  gcfc_pkg::cfg_idx_t              cfg_index,
    input  logic [gcfc_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // cell index items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gcfc_pkg::in_item_t              s_data,

    // visibility results
    output logic                            m_valid,
    input  logic                            m_ready,
    output gcfc_pkg::out_item_t             m_data
);

    // Whole pipeline moves together; it stops only when the skid is full,
    // so ready is a register and never depends on m_ready combinationally.
    logic                adv;
    logic                in_acc;

    logic                chain_valid [gcfc_pkg::NUM_PLANES+1];
    gcfc_pkg::tok_t      chain_tok   [gcfc_pkg::NUM_PLANES+1];

    gcfc_pkg::out_item_t pipe_item;
    logic                pipe_valid;
    logic                m_take;

    logic                m_valid_reg;
    gcfc_pkg::out_item_t m_data_reg;
    logic                skid_valid_reg;
    gcfc_pkg::out_item_t skid_data_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign in_acc  = s_valid && s_ready;

    // front end: box bounds and off-grid flag
    gcfc_box #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS)
    ) u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_acc),
        .in_item   (s_data),
        .out_valid (chain_valid[0]),
        .out_tok   (chain_tok[0])
    );

    // one cell per plane; each ORs its verdict into the item's flags
    for (genvar p = 0; p < gcfc_pkg::NUM_PLANES; p++) begin : g_plane
        gcfc_plane_cell #(
            .REG_SEL (gcfc_pkg::REG_PLANE0 + gcfc_pkg::cfg_idx_t'(p))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .cfg_wr_en (cfg_wr_en),
            .cfg_index (cfg_index),
            .cfg_wdata (cfg_wdata),
            .in_valid  (chain_valid[p]),
            .in_tok    (chain_tok[p]),
            .out_valid (chain_valid[p+1]),
            .out_tok   (chain_tok[p+1])
        );
    end

    // culled covers both an off-grid index and a plane with all corners out
    assign pipe_valid             = chain_valid[gcfc_pkg::NUM_PLANES];
    assign pipe_item.visible      = !chain_tok[gcfc_pkg::NUM_PLANES].culled;
    assign pipe_item.fully_inside = !chain_tok[gcfc_pkg::NUM_PLANES].culled &&
                                    !chain_tok[gcfc_pkg::NUM_PLANES].clipped;

    assign m_take = m_valid_reg && m_ready;

    // output register plus skid: a new item lands in the skid when the
    // output is stalled, which then freezes the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (!m_valid_reg || m_take) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_take) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (pipe_valid) begin
            if (!m_valid_reg || m_take) begin
                m_data_reg <= pipe_item;
            end else begin
                skid_data_reg <= pipe_item;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // skid only ever holds an item behind a waiting output item
    `GCFC_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, m_valid_reg)

    // a result cannot be fully inside without being visible
    `GCFC_ASSERT_IMP(a_full_implies_vis, m_valid_reg && m_data_reg.fully_inside,
                     m_data_reg.visible)

    // a stalled output with an arriving item fills the skid and drops ready
    `GCFC_ASSERT_NXT(a_stall_fills_skid,
                     m_valid_reg && !m_ready && pipe_valid && !skid_valid_reg,
                     skid_valid_reg && !s_ready)

    // the skid drains into the output once the waiting item is taken
    `GCFC_ASSERT_NXT(a_skid_drains, skid_valid_reg && m_ready,
                     !skid_valid_reg && m_valid_reg)

endmodule
